// ===== rtl/core/hfl_pkg.sv =====
// shared types, widths and codes of the handle allocator
package hfl_pkg;

  localparam int HANDLE_W    = 10;
  localparam int CAP_W       = 11;
  localparam int STRIDE_W    = 13;
  localparam int ADDR_W      = 48;
  localparam int STATUS_W    = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 48;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int PROD_W      = STRIDE_W + HANDLE_W;

  localparam int MAX_HANDLES_DEF = 1024;

  localparam logic [CAP_W-1:0]    CAPACITY_RST = CAP_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RST   = STRIDE_W'(32);
  localparam logic [ADDR_W-1:0]   BASE_RST     = '0;
  localparam logic [CAP_W-1:0]    NEXT_RST     = CAP_W'(1);

  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_STRIDE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_BASE   = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK            = 2'd0,
    STATUS_FULL          = 2'd1,
    STATUS_NOT_ISSUED    = 2'd2,
    STATUS_ALREADY_FREED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

endpackage

// ===== rtl/core/handle_allocator_fifo_free_list.sv =====
// top level of the descriptor slot handle allocator with a fifo free list
//
// Each request passes through two steps: the accept, while the free queue and the
// freed-mark memory are read, and the decision, which updates both memories and the
// counters and starts the slot address multiply; the address add runs in a
// following stage that overlaps the next request. A new request is taken only
// after the last one is decided and while the result stage can move. After reset the
// freed-mark memory is cleared one entry a cycle with in_tready low;
// configuration writes are taken throughout.
module handle_allocator_fifo_free_list #(
  parameter int MAX_HANDLES = hfl_pkg::MAX_HANDLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hfl_pkg::IN_TDATA_W-1:0]  in_tdata,   // handle_in
  input  logic                            in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hfl_pkg::OUT_TDATA_W-1:0] out_tdata,  // handle_out, slot_address
  output logic [hfl_pkg::STATUS_W-1:0]    out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [hfl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hfl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PW    = $clog2(MAX_HANDLES);
  localparam int MAXW  = $clog2(MAX_HANDLES + 1);
  localparam int CMP_W = (MAXW > hfl_pkg::CAP_W) ? MAXW : hfl_pkg::CAP_W;
  localparam int PAD_W = hfl_pkg::OUT_TDATA_W - hfl_pkg::ADDR_W - hfl_pkg::HANDLE_W;
  localparam logic [PW-1:0]    LAST_IDX = PW'(MAX_HANDLES - 1);
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_HANDLES);

  logic [hfl_pkg::CAP_W-1:0]    capacity_r;
  logic [hfl_pkg::STRIDE_W-1:0] stride_r;
  logic [hfl_pkg::ADDR_W-1:0]   base_r;

  hfl_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]                clr_idx_r, clr_idx_nxt;
  logic [hfl_pkg::CAP_W-1:0]    next_index_r, next_index_nxt;
  logic [PW-1:0]                head_r, head_nxt;
  logic [PW-1:0]                tail_r, tail_nxt;
  logic [PW:0]                  count_r, count_nxt;
  logic                         func_r;
  logic [hfl_pkg::HANDLE_W-1:0] hin_r;

  logic                         p_v_r;
  logic [hfl_pkg::HANDLE_W-1:0] p_handle_r;
  logic [hfl_pkg::PROD_W-1:0]   p_prod_r;
  hfl_pkg::status_t             p_status_r;

  logic                         out_v_r;
  logic [hfl_pkg::HANDLE_W-1:0] out_handle_r;
  logic [hfl_pkg::ADDR_W-1:0]   out_addr_r;
  hfl_pkg::status_t             out_status_r;

  logic                         q_we;
  logic [PW-1:0]                q_waddr;
  logic [hfl_pkg::HANDLE_W-1:0] q_wdata;
  logic [hfl_pkg::HANDLE_W-1:0] q_rdata;
  logic                         m_we;
  logic [PW-1:0]                m_waddr;
  logic [0:0]                   m_wdata;
  logic [0:0]                   m_rdata;

  logic                         accept;
  logic                         p_move;
  logic [hfl_pkg::HANDLE_W-1:0] h_sel;
  hfl_pkg::status_t             st_sel;
  logic [CMP_W-1:0]             eff_cap;
  logic                         heap_full;
  logic                         not_issued;

  hfl_ram #(.WIDTH(hfl_pkg::HANDLE_W), .DEPTH(MAX_HANDLES)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  hfl_ram #(.WIDTH(1), .DEPTH(MAX_HANDLES)) u_mark (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (PW'(in_tdata[hfl_pkg::HANDLE_W-1:0])),
    .rdata (m_rdata)
  );

  assign in_tready = (state_r == hfl_pkg::ST_IDLE) && (!p_v_r || !out_v_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign p_move    = p_v_r && (!out_v_r || out_tready);

  assign eff_cap    = (CMP_W'(capacity_r) < MAX_CMP) ? CMP_W'(capacity_r) : MAX_CMP;
  assign heap_full  = CMP_W'(next_index_r) >= eff_cap;
  assign not_issued = (hin_r == '0) || (CMP_W'(hin_r) >= CMP_W'(next_index_r))
                      || (CMP_W'(hin_r) >= MAX_CMP);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    next_index_nxt = next_index_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    q_we           = 1'b0;
    q_waddr        = tail_r;
    q_wdata        = hin_r;
    m_we           = 1'b0;
    m_waddr        = clr_idx_r;
    m_wdata        = 1'b0;
    h_sel          = hin_r;
    st_sel         = hfl_pkg::STATUS_OK;
    case (state_r)
      hfl_pkg::ST_CLEAR: begin
        m_we        = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = hfl_pkg::ST_IDLE;
        end
      end
      hfl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = hfl_pkg::ST_EXEC;
        end
      end
      hfl_pkg::ST_EXEC: begin
        state_nxt = hfl_pkg::ST_IDLE;
        if (func_r == hfl_pkg::FUNC_ALLOC) begin
          if (count_r != '0) begin
            h_sel     = q_rdata;
            head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            m_we      = 1'b1;
            m_waddr   = PW'(q_rdata);
            m_wdata   = 1'b0;
          end else if (heap_full) begin
            h_sel  = '0;
            st_sel = hfl_pkg::STATUS_FULL;
          end else begin
            h_sel          = next_index_r[hfl_pkg::HANDLE_W-1:0];
            next_index_nxt = next_index_r + 1'b1;
          end
        end else if (not_issued) begin
          st_sel = hfl_pkg::STATUS_NOT_ISSUED;
        end else if (m_rdata[0]) begin
          st_sel = hfl_pkg::STATUS_ALREADY_FREED;
        end else begin
          q_we      = 1'b1;
          tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
          m_we      = 1'b1;
          m_waddr   = PW'(hin_r);
          m_wdata   = 1'b1;
        end
      end
      default: begin
        state_nxt = hfl_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= hfl_pkg::CAPACITY_RST;
      stride_r     <= hfl_pkg::STRIDE_RST;
      base_r       <= hfl_pkg::BASE_RST;
      state_r      <= hfl_pkg::ST_CLEAR;
      clr_idx_r    <= '0;
      next_index_r <= hfl_pkg::NEXT_RST;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      p_v_r        <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          hfl_pkg::CFG_CAPACITY:    capacity_r <= cfg_wdata[hfl_pkg::CAP_W-1:0];
          hfl_pkg::CFG_SLOT_STRIDE: stride_r   <= cfg_wdata[hfl_pkg::STRIDE_W-1:0];
          hfl_pkg::CFG_HEAP_BASE:   base_r     <= cfg_wdata[hfl_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      next_index_r <= next_index_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      if (state_r == hfl_pkg::ST_EXEC) begin
        p_v_r <= 1'b1;
      end else if (p_move) begin
        p_v_r <= 1'b0;
      end
      if (p_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_tuser;
      hin_r  <= in_tdata[hfl_pkg::HANDLE_W-1:0];
    end
    if (state_r == hfl_pkg::ST_EXEC) begin
      p_handle_r <= h_sel;
      p_prod_r   <= hfl_pkg::PROD_W'(stride_r) * hfl_pkg::PROD_W'(h_sel);
      p_status_r <= st_sel;
    end
    if (p_move) begin
      out_handle_r <= p_handle_r;
      out_status_r <= p_status_r;
      out_addr_r   <= (p_status_r == hfl_pkg::STATUS_FULL) ? '0
                      : base_r + hfl_pkg::ADDR_W'(p_prod_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_addr_r, out_handle_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/core/hfl_ram.sv =====
// generic single write port ram with registered read
module hfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/hfl_checker.sv =====
// port level checks of the handle allocator and their binding
module hfl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hfl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [hfl_pkg::STATUS_W-1:0]    out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a request is decided before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken during decision cycle");

  // heap full carries handle zero and address zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == hfl_pkg::STATUS_FULL) |-> (out_tdata == '0))
    else $error("heap full result not zero");

  // reserved handle zero never succeeds
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == hfl_pkg::STATUS_OK)
    |-> (out_tdata[hfl_pkg::HANDLE_W-1:0] != '0))
    else $error("handle zero reported ok");

endmodule

bind handle_allocator_fifo_free_list hfl_checker u_hfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
